FILE: hw/rtl/srqlink_pkg.sv
// types, codes and constants shared by the srq two byte link
package srqlink_pkg;

    localparam int unsigned CfgWidth   = 8;
    localparam int unsigned CfgIdxBits = 2;

    localparam logic [CfgWidth-1:0] SetupReset  = 8'd10;
    localparam logic [CfgWidth-1:0] HoldReset   = 8'd31;
    localparam logic [CfgWidth-1:0] SettleReset = 8'd6;

    localparam logic [CfgIdxBits-1:0] CFG_SETUP  = 2'd0;
    localparam logic [CfgIdxBits-1:0] CFG_HOLD   = 2'd1;
    localparam logic [CfgIdxBits-1:0] CFG_SETTLE = 2'd2;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_W_WAIT     = 4'd1;
    localparam logic [3:0] PH_W_SETUP    = 4'd2;
    localparam logic [3:0] PH_W_HOLD     = 4'd3;
    localparam logic [3:0] PH_R_WAIT_SET = 4'd4;
    localparam logic [3:0] PH_R_WAIT_REL = 4'd5;
    localparam logic [3:0] PH_R_SETTLE   = 4'd6;

    localparam logic [3:0] BitsPerByte = 4'd8;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] tx_first;
        logic [7:0] tx_second;
        logic       srq_asserted;
        logic       data_asserted;
        logic       clk_asserted;
        logic       abort_wait;
    } t_in_item;

    typedef struct packed {
        logic       drive_srq;
        logic       drive_data;
        logic       drive_clk;
        logic       busy_res;
        logic       done_res;
        logic       aborted;
        logic [7:0] rx_first;
        logic [7:0] rx_second;
    } t_out_item;

    typedef struct packed {
        logic [CfgWidth-1:0] setup_ticks;
        logic [CfgWidth-1:0] hold_ticks;
        logic [CfgWidth-1:0] settle_ticks;
    } t_cfg;

    typedef struct packed {
        logic [3:0] phase;
        logic       byte_index;
        logic [3:0] bits_left;
        logic [7:0] shift_byte;
        logic [7:0] second_tx_byte;
        logic [7:0] delay_count;
        logic [7:0] first_rx_byte;
        logic       drv_srq;
        logic       drv_data;
        logic       drv_clk;
    } t_state;

endpackage

FILE: hw/rtl/srqlink_step.sv
// next state and result of the link for one bus tick
module srqlink_step (
    input  srqlink_pkg::t_state    i_state,
    input  srqlink_pkg::t_cfg      i_cfg,
    input  srqlink_pkg::t_in_item  i_item,
    output srqlink_pkg::t_state    o_state,
    output srqlink_pkg::t_out_item o_result
);
    import srqlink_pkg::*;

    t_state     s;
    logic       done;
    logic       abo;
    logic [7:0] rxa;
    logic [7:0] rxb;
    logic [3:0] bits_dec;
    logic [7:0] rx_shift;

    assign bits_dec = i_state.bits_left - 4'd1;
    assign rx_shift = {i_state.shift_byte[6:0], ~i_item.data_asserted};

    always_comb begin
        s    = i_state;
        done = 1'b0;
        abo  = 1'b0;
        rxa  = '0;
        rxb  = '0;
        unique case (i_state.phase)
            PH_IDLE: begin
                if (i_item.req_type == REQ_WRITE) begin
                    s.shift_byte     = i_item.tx_first;
                    s.second_tx_byte = i_item.tx_second;
                    s.byte_index     = 1'b0;
                    s.bits_left      = BitsPerByte;
                    s.phase          = PH_W_WAIT;
                end else if (i_item.req_type == REQ_READ) begin
                    s.drv_data   = 1'b0;
                    s.drv_clk    = 1'b1;
                    s.shift_byte = '0;
                    s.byte_index = 1'b0;
                    s.bits_left  = BitsPerByte;
                    s.phase      = PH_R_WAIT_SET;
                end
            end
            PH_W_WAIT: begin
                if (i_state.byte_index == i_item.clk_asserted ? 1'b0 : 1'b1) begin
                    s.bits_left   = BitsPerByte;
                    s.drv_srq     = 1'b1;
                    s.drv_data    = ~i_state.shift_byte[7];
                    s.shift_byte  = {i_state.shift_byte[6:0], 1'b0};
                    s.delay_count = i_cfg.setup_ticks;
                    s.phase       = PH_W_SETUP;
                end else if (i_item.abort_wait) begin
                    s.phase = PH_IDLE;
                    done    = 1'b1;
                    abo     = 1'b1;
                end
            end
            PH_W_SETUP: begin
                if (i_state.delay_count == '0) begin
                    s.drv_srq     = 1'b0;
                    s.delay_count = i_cfg.hold_ticks;
                    s.phase       = PH_W_HOLD;
                end else begin
                    s.delay_count = i_state.delay_count - 8'd1;
                end
            end
            PH_W_HOLD: begin
                if (i_state.delay_count != '0) begin
                    s.delay_count = i_state.delay_count - 8'd1;
                end else begin
                    s.bits_left = bits_dec;
                    if (bits_dec != '0) begin
                        s.drv_srq     = 1'b1;
                        s.drv_data    = ~i_state.shift_byte[7];
                        s.shift_byte  = {i_state.shift_byte[6:0], 1'b0};
                        s.delay_count = i_cfg.setup_ticks;
                        s.phase       = PH_W_SETUP;
                    end else if (!i_state.byte_index) begin
                        s.byte_index = 1'b1;
                        s.shift_byte = i_state.second_tx_byte;
                        s.phase      = PH_W_WAIT;
                    end else begin
                        s.phase = PH_IDLE;
                        done    = 1'b1;
                    end
                end
            end
            PH_R_WAIT_SET: begin
                if (i_item.srq_asserted) begin
                    s.phase = PH_R_WAIT_REL;
                end
            end
            PH_R_WAIT_REL: begin
                if (!i_item.srq_asserted) begin
                    s.delay_count = i_cfg.settle_ticks;
                    s.phase       = PH_R_SETTLE;
                end
            end
            PH_R_SETTLE: begin
                if (i_state.delay_count != '0) begin
                    s.delay_count = i_state.delay_count - 8'd1;
                end else begin
                    s.shift_byte = rx_shift;
                    s.bits_left  = bits_dec;
                    if (bits_dec != '0) begin
                        s.phase = PH_R_WAIT_SET;
                    end else if (!i_state.byte_index) begin
                        s.first_rx_byte = rx_shift;
                        s.shift_byte    = '0;
                        s.byte_index    = 1'b1;
                        s.bits_left     = BitsPerByte;
                        s.drv_clk       = 1'b0;
                        s.phase         = PH_R_WAIT_SET;
                    end else begin
                        rxa     = i_state.first_rx_byte;
                        rxb     = rx_shift;
                        s.phase = PH_IDLE;
                        done    = 1'b1;
                    end
                end
            end
            default: begin
                s.phase = PH_IDLE;
            end
        endcase
    end

    assign o_state = s;

    always_comb begin
        o_result.drive_srq  = s.drv_srq;
        o_result.drive_data = s.drv_data;
        o_result.drive_clk  = s.drv_clk;
        o_result.busy_res   = (s.phase != PH_IDLE);
        o_result.done_res   = done;
        o_result.aborted    = abo;
        o_result.rx_first   = rxa;
        o_result.rx_second  = rxb;
    end

endmodule

FILE: hw/rtl/srq_clocked_two_byte_link.sv
// top level of the srq clocked two byte serial link host
//
//  channel | direction | handshake              | payload
//  in      | to block  | i_in_valid / o_in_stall | t_in_item, one bus tick
//  out     | from block| o_out_valid / i_out_stall| t_out_item, one per tick
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| index and 8 bit data
//
// one request per clock unless in stalls; its result is registered on acceptance
// link state and the output register are updated in the same cycle as acceptance
// in stalls only while a result is held and out is stalled
// synchronous active low reset clears link state and restores register defaults
module srq_clocked_two_byte_link (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  srqlink_pkg::t_in_item                    i_in_data,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output srqlink_pkg::t_out_item                   o_out_data,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [srqlink_pkg::CfgIdxBits-1:0]       i_cfg_index,
    input  logic [srqlink_pkg::CfgWidth-1:0]         i_cfg_data
);
    import srqlink_pkg::*;

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      in_fire;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_fire     = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    srqlink_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (i_in_data),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setup_ticks  <= SetupReset;
            r_cfg.hold_ticks   <= HoldReset;
            r_cfg.settle_ticks <= SettleReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SETUP:  r_cfg.setup_ticks  <= i_cfg_data;
                CFG_HOLD:   r_cfg.hold_ticks   <= i_cfg_data;
                CFG_SETTLE: r_cfg.settle_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.done_res && o_out_data.busy_res))
        else $error("done reported while still busy");

    a_abort_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.aborted) |-> o_out_data.done_res)
        else $error("abort flag without done");

    a_rx_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.done_res) |->
            (o_out_data.rx_first == '0 && o_out_data.rx_second == '0))
        else $error("received bytes shown without done");

    a_bits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bits_left <= BitsPerByte)
        else $error("bit counter out of range");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");
`endif

endmodule
